[design/mlfg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfg_pkg
// Shared types and constants for the multiplicative lagged Fibonacci
// generator: operation codes, the command passed from front to back, and
// fixed field widths.
// ----------------------------------------------------------------------------
package mlfg_pkg;

    localparam int WORD_W      = 64;
    localparam int HALF_W      = 32;
    localparam int SEED_IDX_W  = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_AW      = $clog2(OUT_DEPTH);

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_GEN  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic                  wr_en;
        logic [SEED_IDX_W-1:0] slot;
        logic [WORD_W-1:0]     seed;
    } t_cmd;

endpackage

[design/mlfg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfg_front
// Input stage. Accepts transactions, decodes the operation and the seed
// entry, and hands each decoded command to the command queue.
// ----------------------------------------------------------------------------
module mlfg_front #(
    parameter int LONG_LAG = 17
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_operation,
    input  logic [mlfg_pkg::SEED_IDX_W-1:0] i_seed_index,
    input  logic [mlfg_pkg::WORD_W-1:0]     i_seed_word,
    input  logic                           i_busy,
    input  logic                           i_full,
    output logic                           o_push,
    output mlfg_pkg::t_cmd                 o_cmd
);
    import mlfg_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_cmd  r_cmd;
    t_cmd  w_cmd;
    logic  w_accept;
    logic  w_in_range;

    assign w_in_range = (i_seed_index != '0) && (32'(i_seed_index) <= 32'(LONG_LAG));

    always_comb begin
        w_cmd.op    = t_op'(i_operation);
        w_cmd.wr_en = (t_op'(i_operation) == OP_LOAD) && w_in_range;
        w_cmd.slot  = i_seed_index - SEED_IDX_W'(1);
        w_cmd.seed  = i_seed_word;
    end

    assign o_stall  = i_busy || (r_valid && i_full);
    assign w_accept = i_valid && !o_stall;
    assign o_push   = r_valid && !i_full;
    assign o_cmd    = r_cmd;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= w_cmd;
        end
    end

endmodule

[design/mlfg_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfg_queue
// Short command queue between the front and the back, so that each side
// can stall without holding up the other.
// ----------------------------------------------------------------------------
module mlfg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mlfg_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output mlfg_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import mlfg_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_head;
    logic [QUEUE_AW-1:0] r_tail;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW:0]   n_count;
    logic                w_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_head];
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (w_pop) begin
                r_head <= r_head + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_cmd;
        end
    end

endmodule

[design/mlfg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfg_back
// Execution part. Holds the lag ring and both lag pointers, issues one
// command per cycle while not held back, into a two-stage 64-bit multiplier,
// writes results back into the ring and buffers them for the output channel.
// ----------------------------------------------------------------------------
module mlfg_back #(
    parameter int LONG_LAG  = 17,
    parameter int SHORT_LAG = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  mlfg_pkg::t_cmd             i_cmd,
    output logic                       o_pop,
    output logic                       o_busy,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [mlfg_pkg::WORD_W-1:0] o_random_word
);
    import mlfg_pkg::*;

    localparam int SLOT_W = $clog2(LONG_LAG);
    localparam logic [SLOT_W-1:0] LONG_SLOT  = SLOT_W'(LONG_LAG - 1);
    localparam logic [SLOT_W-1:0] SHORT_SLOT = SLOT_W'((SHORT_LAG - 1) % LONG_LAG);

    logic [WORD_W-1:0] r_ring [LONG_LAG];
    logic [SLOT_W-1:0] r_long;
    logic [SLOT_W-1:0] r_short;
    logic              r_clearing;
    logic [SLOT_W-1:0] r_clr_addr;

    logic              w_gen;
    logic              w_hazard;
    logic              w_issue;
    logic [OUT_AW+1:0] w_pend;
    logic [31:0]       w_slot32;
    logic [SLOT_W-1:0] w_seed_slot;

    logic [WORD_W-1:0] r_rd_a;
    logic [WORD_W-1:0] r_rd_b;
    logic              r_v1;
    logic              r_gen1;
    logic              r_we1;
    logic [SLOT_W-1:0] r_addr1;
    logic [WORD_W-1:0] r_seed1;

    logic              r_v2;
    logic              r_gen2;
    logic              r_we2;
    logic [SLOT_W-1:0] r_addr2;
    logic [WORD_W-1:0] r_seed2;
    logic [WORD_W-1:0] r_pll;
    logic [HALF_W-1:0] r_phl;
    logic [HALF_W-1:0] r_plh;

    logic [WORD_W-1:0] w_pll;
    logic [HALF_W-1:0] w_phl;
    logic [HALF_W-1:0] w_plh;
    logic [WORD_W-1:0] w_product;

    logic              w_we;
    logic [SLOT_W-1:0] w_waddr;
    logic [WORD_W-1:0] w_wdata;

    logic [WORD_W-1:0] r_oq [OUT_DEPTH];
    logic [OUT_AW-1:0] r_ohead;
    logic [OUT_AW-1:0] r_otail;
    logic [OUT_AW:0]   r_ocnt;
    logic              w_push;
    logic              w_opop;

    assign w_gen       = (i_cmd.op == OP_GEN);
    assign w_slot32    = 32'(i_cmd.slot);
    assign w_seed_slot = w_slot32[SLOT_W-1:0];

    assign w_hazard = w_gen && (
        (r_v1 && r_we1 && ((r_addr1 == r_long) || (r_addr1 == r_short))) ||
        (r_v2 && r_we2 && ((r_addr2 == r_long) || (r_addr2 == r_short))));

    assign w_pend  = (OUT_AW+2)'(r_ocnt) + (OUT_AW+2)'(r_v1) + (OUT_AW+2)'(r_v2);
    assign w_issue = i_cmd_valid && !r_clearing && !w_hazard
                     && (w_pend < (OUT_AW+2)'(OUT_DEPTH));
    assign o_pop   = w_issue;
    assign o_busy  = r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_long     <= LONG_SLOT;
            r_short    <= SHORT_SLOT;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LONG_SLOT) begin
                    r_clearing <= 1'b0;
                end
            end
            if (w_issue) begin
                if (w_gen) begin
                    r_long  <= (r_long == '0) ? LONG_SLOT : r_long - 1'b1;
                    r_short <= (r_short == '0) ? LONG_SLOT : r_short - 1'b1;
                end else begin
                    r_long  <= LONG_SLOT;
                    r_short <= SHORT_SLOT;
                end
            end
            r_v1 <= w_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gen1  <= w_gen;
        r_we1   <= w_gen || i_cmd.wr_en;
        r_addr1 <= w_gen ? r_long : w_seed_slot;
        r_seed1 <= i_cmd.seed;
    end

    assign w_pll = r_rd_a[HALF_W-1:0] * r_rd_b[HALF_W-1:0];
    assign w_phl = r_rd_a[WORD_W-1:HALF_W] * r_rd_b[HALF_W-1:0];
    assign w_plh = r_rd_a[HALF_W-1:0] * r_rd_b[WORD_W-1:HALF_W];

    always_ff @(posedge i_clk) begin
        r_gen2  <= r_gen1;
        r_we2   <= r_we1;
        r_addr2 <= r_addr1;
        r_seed2 <= r_seed1;
        r_pll   <= w_pll;
        r_phl   <= w_phl;
        r_plh   <= w_plh;
    end

    assign w_product = r_pll + {r_phl + r_plh, {HALF_W{1'b0}}};

    always_comb begin
        if (r_clearing) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = WORD_W'(1);
        end else begin
            w_we    = r_v2 && r_we2;
            w_waddr = r_addr2;
            w_wdata = r_gen2 ? w_product : (r_seed2 | WORD_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_ring[r_long];
        r_rd_b <= r_ring[r_short];
        if (w_we) begin
            r_ring[w_waddr] <= w_wdata;
        end
    end

    assign w_push        = r_v2 && r_gen2;
    assign o_valid       = (r_ocnt != '0);
    assign o_random_word = r_oq[r_ohead];
    assign w_opop        = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ohead <= '0;
            r_otail <= '0;
            r_ocnt  <= '0;
        end else begin
            if (w_push) begin
                r_otail <= r_otail + 1'b1;
            end
            if (w_opop) begin
                r_ohead <= r_ohead + 1'b1;
            end
            if (w_push && !w_opop) begin
                r_ocnt <= r_ocnt + 1'b1;
            end else if (!w_push && w_opop) begin
                r_ocnt <= r_ocnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_oq[r_otail] <= w_product;
        end
    end

    a_no_issue_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) r_clearing |-> !w_issue)
        else $error("Command issued during the ring clearing pass.");

    a_out_no_overflow: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_opop) |-> (r_ocnt < (OUT_AW+1)'(OUT_DEPTH)))
        else $error("Result buffer overflow.");

    a_issue_reaches_stage2: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_issue |=> ##1 r_v2)
        else $error("Issued command did not reach the write-back stage.");

    a_no_result_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) r_clearing |-> !o_valid)
        else $error("Result presented during the ring clearing pass.");

endmodule

[design/multiplicative_lagged_fibonacci_rng_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiplicative_lagged_fibonacci_rng_top
// Multiplicative lagged Fibonacci generator modulo 2^64, LONG_LAG and SHORT_LAG.
//
// A load transaction writes the seed word, with bit 0 set, into ring entry
// seed_index (1 to LONG_LAG) and resets both lag pointers; it has no output.
// A generate transaction produces one 64-bit word, in acceptance order.
// A word passes the input register, the command queue, the ring read, the
// partial products and the final sum on its way to the result buffer and
// the output. One transaction is taken per cycle while o_stall is low. A
// generate is held back while its ring read would hit a word still in the
// two-stage multiplier: right after a load of one of the two lagged
// entries, and every step when SHORT_LAG is below three.
// After reset every ring entry is set to one, while o_stall is high. When
// the receiver stalls, up to four results are buffered, and then the
// input side stalls in turn.
// ----------------------------------------------------------------------------
module multiplicative_lagged_fibonacci_rng_top #(
    parameter int LONG_LAG  = 17,
    parameter int SHORT_LAG = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_operation,
    input  logic [mlfg_pkg::SEED_IDX_W-1:0] i_seed_index,
    input  logic [mlfg_pkg::WORD_W-1:0]     i_seed_word,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [mlfg_pkg::WORD_W-1:0]     o_random_word
);
    import mlfg_pkg::*;

    logic busy;
    logic q_full;
    logic q_push;
    t_cmd front_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    mlfg_front #(
        .LONG_LAG (LONG_LAG)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_seed_index (i_seed_index),
        .i_seed_word  (i_seed_word),
        .i_busy       (busy),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_cmd        (front_cmd)
    );

    mlfg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    mlfg_back #(
        .LONG_LAG  (LONG_LAG),
        .SHORT_LAG (SHORT_LAG)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_cmd),
        .o_pop         (q_pop),
        .o_busy        (busy),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_random_word (o_random_word)
    );

endmodule

[test/multiplicative_lagged_fibonacci_rng_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiplicative_lagged_fibonacci_rng_top_tb
// Self-checking bench for the multiplicative lagged Fibonacci generator.
// Seed loads and generate requests are driven into the block with random
// gaps and output back-pressure. A scoreboard keeps its own lag ring and
// pointers, predicts every generated word, and compares each output
// transaction in order with the oldest prediction.
// ----------------------------------------------------------------------------
class rng_scoreboard #(int LONG_LAG = 17, int SHORT_LAG = 5);
    logic [63:0] lag_ring [1:LONG_LAG];
    int unsigned long_ptr;
    int unsigned short_ptr;
    logic [63:0] pending_words [$];
    int unsigned checked;
    int unsigned errors;

    function new();
        for (int k = 1; k <= LONG_LAG; k++) lag_ring[k] = 64'h1;
        long_ptr   = LONG_LAG;
        short_ptr  = SHORT_LAG;
        checked    = 0;
        errors     = 0;
    endfunction

    function int unsigned entry_of(int unsigned p);
        return (p == 0) ? LONG_LAG : ((p - 1) % LONG_LAG) + 1;
    endfunction

    function int unsigned step_down(int unsigned p);
        return (p <= 1) ? LONG_LAG : p - 1;
    endfunction

    function void note_input(mlfg_pkg::t_op op, logic [4:0] idx, logic [63:0] word);
        logic [63:0] product;
        int unsigned a;
        int unsigned b;
        if (op == mlfg_pkg::OP_LOAD) begin
            if (idx >= 1 && idx <= LONG_LAG) lag_ring[idx] = word | 64'h1;
            long_ptr  = LONG_LAG;
            short_ptr = SHORT_LAG;
        end else begin
            a = entry_of(long_ptr);
            b = entry_of(short_ptr);
            product = lag_ring[a] * lag_ring[b];
            lag_ring[a] = product;
            long_ptr  = step_down(long_ptr);
            short_ptr = step_down(short_ptr);
            pending_words.push_back(product);
        end
    endfunction

    task report(string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    task check_result(logic [63:0] got);
        logic [63:0] want;
        checked++;
        if (pending_words.size() == 0) begin
            report($sformatf("unexpected random_word %h in transaction %0d", got, checked));
        end else begin
            want = pending_words.pop_front();
            if (got !== want)
                report($sformatf("random_word %h, expected %h in transaction %0d",
                                 got, want, checked));
        end
    endtask
endclass

module multiplicative_lagged_fibonacci_rng_top_tb;
    import mlfg_pkg::*;

    localparam int LONG_LAG        = 17;
    localparam int SHORT_LAG       = 5;
    localparam int ITEM_TARGET     = 1650;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 20;
    localparam int CYCLE_LIMIT     = 200000;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic                  o_stall;
    t_op                   i_operation  = OP_LOAD;
    logic [SEED_IDX_W-1:0] i_seed_index = '0;
    logic [WORD_W-1:0]     i_seed_word  = '0;
    logic                  o_valid;
    logic                  i_stall      = 1'b0;
    logic [WORD_W-1:0]     o_random_word;

    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    int unsigned hold_cnt   = 0;
    int unsigned sent       = 0;
    int unsigned cycles     = 0;

    rng_scoreboard #(LONG_LAG, SHORT_LAG) sb;

    multiplicative_lagged_fibonacci_rng_top #(
        .LONG_LAG (LONG_LAG),
        .SHORT_LAG(SHORT_LAG)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_seed_index (i_seed_index),
        .i_seed_word  (i_seed_word),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_random_word(o_random_word)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(15);
        if (pick == 0) return 64'h0;
        if (pick == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(t_op op, logic [4:0] idx, logic [63:0] word);
        if (tx_idle_en && $urandom_range(99) < 7) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_seed_index <= idx;
        i_seed_word  <= word;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(op, idx, word);
        sent++;
    endtask

    task automatic generate_run(int unsigned n);
        repeat (n) send_item(OP_GEN, 5'($urandom_range(31)), rand_word());
    endtask

    task automatic reseed_ring();
        logic [4:0] order [LONG_LAG];
        logic [4:0] tmp;
        int unsigned j;
        for (int k = 0; k < LONG_LAG; k++) order[k] = 5'(k + 1);
        for (int k = LONG_LAG - 1; k > 0; k--) begin
            j = $urandom_range(k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < LONG_LAG; k++) send_item(OP_LOAD, order[k], rand_word());
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_words.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cnt != 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= rx_idle_en && ($urandom_range(99) < 7);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("multiplicative_lagged_fibonacci_rng_top_tb NOT OK");
            $finish;
        end else if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_random_word);
        end
    end

    initial begin
        int unsigned phase;
        int unsigned pick;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Generating from the reset ring, loads outside the ring, extreme
        // seed words, and generates that carry extreme seed fields.
        send_item(OP_GEN, 5'd0, 64'h0);
        send_item(OP_GEN, 5'd31, '1);
        send_item(OP_LOAD, 5'd0, '1);
        send_item(OP_LOAD, 5'd31, 64'h0);
        send_item(OP_LOAD, 5'd18, 64'h0);
        send_item(OP_LOAD, 5'd17, '1);
        send_item(OP_LOAD, 5'd5, 64'h8000_0000_0000_0000);
        send_item(OP_LOAD, 5'd1, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(OP_LOAD, 5'd16, 64'h5555_5555_5555_5554);
        send_item(OP_LOAD, 5'd4, 64'h0);
        for (int k = 0; k < 14; k++)
            send_item(OP_GEN, k[0] ? 5'd31 : 5'd0, k[0] ? '1 : 64'h0);

        phase = 0;
        while (sent < ITEM_TARGET) begin
            phase++;
            tx_idle_en = !(phase >= 8 && phase < 14);
            rx_idle_en = tx_idle_en;
            if (phase == 4) begin
                hold_cnt = HOLD_OFF_CYCLES;
                generate_run(120);
            end else if (phase == 6 || $urandom_range(99) < 5) begin
                drain_results();
            end else begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    reseed_ring();
                    generate_run($urandom_range(20, 120));
                end else if (pick < 75) begin
                    generate_run($urandom_range(1, 40));
                end else if (pick < 88) begin
                    repeat ($urandom_range(1, 5))
                        send_item(OP_LOAD, 5'($urandom_range(31)), rand_word());
                    generate_run($urandom_range(5, 40));
                end else begin
                    repeat ($urandom_range(4, 16))
                        send_item(t_op'($urandom_range(1)), 5'($urandom_range(31)),
                                  rand_word());
                end
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("multiplicative_lagged_fibonacci_rng_top_tb OK");
        end else begin
            $display("multiplicative_lagged_fibonacci_rng_top_tb NOT OK");
        end
        $finish;
    end
endmodule

[multiplicative_lagged_fibonacci_rng_top.f]
design/mlfg_pkg.sv
design/mlfg_front.sv
design/mlfg_queue.sv
design/mlfg_back.sv
design/multiplicative_lagged_fibonacci_rng_top.sv
test/multiplicative_lagged_fibonacci_rng_top_tb.sv
